// ===== src/rlps_pkg.sv =====
// Package for the ready list priority select block.
// Holds the request mode codes and the controller state type; no dependencies.
package rlps_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT_FRONT = 2'd0,
        MODE_APPEND_BACK  = 2'd1,
        MODE_REMOVE       = 2'd2,
        MODE_SELECT       = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } state_t;

endpackage

// ===== src/rlps_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rlps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ready_list_priority_select_core.sv =====
// Ready list with priority select: top level and list controller.
// Depends on rlps_pkg and rlps_ram.
//
// Insert front / append back give their result in the cycle after the request,
// and so do remove and select on an empty list. Otherwise remove and select walk the
// list through the RAM read port, one entry per cycle, up to the end; a remove that
// hits stops there and compacts the tail. One request is handled at a time; a new
// request is taken the cycle after the previous result has been delivered. rst_n
// clears the list (count and head pointer) at once; the RAM contents are never
// cleared.
module ready_list_priority_select_core #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 8,
    parameter int PRIO_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    // request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [7:0] process_id,
    input  logic [7:0] priority_req,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       ok,
    output logic       error,
    output logic [7:0] selected_id,
    output logic [7:0] selected_priority,
    output logic       is_empty,
    output logic       is_full
);

    import rlps_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ID_BITS + PRIO_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_W    = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

    // The list is a circular buffer in the RAM: logical position i lives at
    // address (head + i) mod DEPTH. Insert at front just moves head back.
    function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] head,
                                                input logic [CW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + (AW+1)'(idx);
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    // Field width adaptation between 8-bit ports and parameter widths
    logic [ID_BITS+7:0]   pid_wide;
    logic [PRIO_BITS+7:0] prio_wide;
    logic [ID_BITS-1:0]   pid_in;
    logic [PRIO_BITS-1:0] prio_in;

    assign pid_wide  = {{ID_BITS{1'b0}}, process_id};
    assign prio_wide = {{PRIO_BITS{1'b0}}, priority_req};
    assign pid_in    = pid_wide[ID_BITS-1:0];
    assign prio_in   = prio_wide[PRIO_BITS-1:0];

    // Control state
    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;   // next logical position to read
    logic [CW-1:0] cmp_idx_reg, cmp_idx_next; // position of data now on rdata
    logic          pend_reg, pend_next;       // rdata holds a valid read
    logic          out_valid_reg, out_valid_next;

    // Payload state
    logic                 is_remove_reg, is_remove_next;
    logic [ID_BITS-1:0]   key_reg, key_next;
    logic [ID_BITS-1:0]   max_id_reg, max_id_next;
    logic [PRIO_BITS-1:0] max_prio_reg, max_prio_next;
    logic                 ok_reg, ok_next;
    logic                 err_reg, err_next;
    logic [ID_BITS-1:0]   sel_id_reg, sel_id_next;
    logic [PRIO_BITS-1:0] sel_prio_reg, sel_prio_next;
    logic                 empty_reg, empty_next;
    logic                 full_reg, full_next;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic [ID_BITS-1:0]   rd_id;
    logic [PRIO_BITS-1:0] rd_prio;

    logic  accept;
    logic  list_full;
    logic  found;
    mode_t req_mode;

    assign rd_id     = ram_rdata[EW-1:PRIO_BITS];
    assign rd_prio   = ram_rdata[PRIO_BITS-1:0];
    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign list_full = (count_reg == FULL_COUNT);
    assign req_mode  = mode_t'(mode);

    rlps_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        is_remove_next = is_remove_reg;
        key_next       = key_reg;
        max_id_next    = max_id_reg;
        max_prio_next  = max_prio_reg;
        ok_next        = ok_reg;
        err_next       = err_reg;
        sel_id_next    = sel_id_reg;
        sel_prio_next  = sel_prio_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;
        ram_we         = 1'b0;
        ram_waddr      = phys_addr(head_reg, count_reg);
        ram_wdata      = {pid_in, prio_in};
        ram_raddr      = phys_addr(head_reg, rd_idx_reg);
        found          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    is_remove_next = (req_mode == MODE_REMOVE);
                    key_next       = pid_in;
                    rd_idx_next    = '0;
                    sel_id_next    = '0;
                    sel_prio_next  = '0;
                    case (req_mode) inside
                        MODE_INSERT_FRONT, MODE_APPEND_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (list_full)
                            begin
                                ok_next  = 1'b0;
                                err_next = 1'b1;
                            end
                            else
                            begin
                                ok_next    = 1'b1;
                                err_next   = 1'b0;
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (req_mode == MODE_INSERT_FRONT)
                                begin
                                    head_next = (head_reg == '0) ? LAST_ADDR
                                                                 : head_reg - 1'b1;
                                    ram_waddr = head_next;
                                end
                            end
                        end
                        default:
                        begin
                            // remove or select: walk the list unless it is empty
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                ok_next        = 1'b0;
                                err_next       = (req_mode == MODE_SELECT);
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                    empty_next = (count_next == '0);
                    full_next  = (count_next == FULL_COUNT);
                end
            end

            ST_SCAN:
            begin
                if (pend_reg)
                begin
                    if (is_remove_reg)
                    begin
                        found = (rd_id == key_reg);
                    end
                    else if ((cmp_idx_reg == '0) || (rd_prio > max_prio_reg))
                    begin
                        // strict compare keeps the earliest of equal maxima
                        max_id_next   = rd_id;
                        max_prio_next = rd_prio;
                    end
                end

                if (found)
                begin
                    // compact: entries after the hit move down one place
                    state_next  = ST_SHIFT;
                    rd_idx_next = cmp_idx_reg + 1'b1;
                end
                else if (rd_idx_reg != count_reg)
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                end
                else
                begin
                    // last entry consumed this cycle
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    err_next       = 1'b0;
                    ok_next        = !is_remove_reg;
                    if (!is_remove_reg)
                    begin
                        sel_id_next   = max_id_next;
                        sel_prio_next = max_prio_next;
                    end
                    empty_next = (count_reg == '0);
                    full_next  = list_full;
                end
            end

            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = phys_addr(head_reg, cmp_idx_reg - 1'b1);
                    ram_wdata = ram_rdata;
                end

                if (rd_idx_reg != count_reg)
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                end
                else
                begin
                    state_next     = ST_IDLE;
                    count_next     = count_reg - 1'b1;
                    out_valid_next = 1'b1;
                    ok_next        = 1'b1;
                    err_next       = 1'b0;
                    empty_next     = (count_next == '0);
                    full_next      = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_idx_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_remove_reg <= is_remove_next;
        key_reg       <= key_next;
        max_id_reg    <= max_id_next;
        max_prio_reg  <= max_prio_next;
        ok_reg        <= ok_next;
        err_reg       <= err_next;
        sel_id_reg    <= sel_id_next;
        sel_prio_reg  <= sel_prio_next;
        empty_reg     <= empty_next;
        full_reg      <= full_next;
    end

    // Result fields back to 8-bit port width
    logic [ID_BITS+7:0]   sel_id_wide;
    logic [PRIO_BITS+7:0] sel_prio_wide;

    assign sel_id_wide   = {8'd0, sel_id_reg};
    assign sel_prio_wide = {8'd0, sel_prio_reg};

    assign out_valid         = out_valid_reg;
    assign ok                = ok_reg;
    assign error             = err_reg;
    assign selected_id       = sel_id_wide[7:0];
    assign selected_priority = sel_prio_wide[7:0];
    assign is_empty          = empty_reg;
    assign is_full           = full_reg;

endmodule
